// ===== sv/wtm_pkg.sv =====
`timescale 1ns / 1ps

package wtm_pkg;

   // Number of thruster commands produced from one wrench
   localparam int MOTOR_COUNT = 8;

   // Motor slots, in the order they are sent
   localparam logic [2:0] SLOT_XLEFT  = 3'd0;
   localparam logic [2:0] SLOT_XRIGHT = 3'd1;
   localparam logic [2:0] SLOT_YFRONT = 3'd2;
   localparam logic [2:0] SLOT_YBACK  = 3'd3;
   localparam logic [2:0] SLOT_ZFL    = 3'd4;
   localparam logic [2:0] SLOT_ZFR    = 3'd5;
   localparam logic [2:0] SLOT_ZBL    = 3'd6;
   localparam logic [2:0] SLOT_ZBR    = 3'd7;

   // Control register indexes
   localparam logic [2:0] CSR_MODE    = 3'd0;
   localparam logic [2:0] CSR_GAIN    = 3'd1;
   localparam logic [2:0] CSR_INV_ARM = 3'd2;
   localparam logic [2:0] CSR_SPD_MAX = 3'd3;
   localparam logic [2:0] CSR_SPD_MIN = 3'd4;
   localparam logic [2:0] CSR_FWD     = 3'd5;
   localparam logic [2:0] CSR_REV     = 3'd6;

   typedef struct packed {
      logic        twelve_motor_mode;
      logic [15:0] cmd_gain;
      logic [15:0] inverse_arm_length;
      logic [6:0]  speed_max;
      logic [6:0]  speed_min;
      logic [7:0]  forward_code;
      logic [7:0]  reverse_code;
   } cfg_type;

   // Input word layout, force_x in the lowest bits
   typedef struct packed {
      logic signed [15:0] torque_z;
      logic signed [15:0] torque_y;
      logic signed [15:0] torque_x;
      logic signed [15:0] force_z;
      logic signed [15:0] force_y;
      logic signed [15:0] force_x;
   } wrench_type;

   // All eight finished commands of one wrench
   typedef struct packed {
      logic [MOTOR_COUNT-1:0][7:0] drive;
      logic [MOTOR_COUNT-1:0]      neg;
      logic [MOTOR_COUNT-1:0]      nz;
   } rec_type;

endpackage

// ===== sv/wtm_front.sv =====
`timescale 1ns / 1ps

module wtm_front import wtm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  wrench_type req_wrench,
   output logic       push,
   output rec_type    push_rec,
   input  logic       full
);

   // Issue stage: one motor slot per cycle from the held wrench, unless stalled
   wrench_type         wr_ff, wr_in;
   logic               iss_valid_ff, iss_valid_in;
   logic [2:0]         iss_slot_ff, iss_slot_in;

   // Stage 1: torque product and force term
   logic signed [34:0] s1_tprod_ff;
   logic [33:0]        s1_fterm_ff;
   logic               s1_tc2_ff;
   logic [2:0]         s1_slot_ff;
   logic               s1_valid_ff;

   // Stage 2: magnitude and sign of the mixed sum
   logic [33:0]        s2_abs_ff;
   logic               s2_neg_ff, s2_nz_ff;
   logic [2:0]         s2_slot_ff;
   logic               s2_valid_ff;

   // Stage 3: gain partial products
   logic [32:0]        s3_pp_hi_ff, s3_pp_lo_ff;
   logic               s3_neg_ff, s3_nz_ff;
   logic [2:0]         s3_slot_ff;
   logic               s3_valid_ff;

   rec_type            asm_ff, asm_in;

   logic               adv, take, m12;
   logic signed [17:0] tx, ty, tz, t_sel;
   logic signed [15:0] f_sel;
   logic signed [34:0] tprod;
   logic [33:0]        fterm;
   logic [35:0]        s_sum, s_abs;
   logic [32:0]        pp_hi, pp_lo;
   logic [49:0]        prod;
   logic [15:0]        mag16;
   logic [6:0]         mag_sat;
   logic [7:0]         drive_pre, drive;

   // Stall everything only when the finished record cannot enter the queue
   assign adv        = !(s3_valid_ff && (s3_slot_ff == SLOT_ZBR) && full);
   assign req_tready = adv && (!iss_valid_ff || (iss_slot_ff == SLOT_ZBR));
   assign take       = req_tvalid && req_tready;
   assign m12        = cfg.twelve_motor_mode;

   // Issue control
   always_comb begin
      wr_in        = wr_ff;
      iss_valid_in = iss_valid_ff;
      iss_slot_in  = iss_slot_ff;
      if (take) begin
         wr_in        = req_wrench;
         iss_valid_in = 1'b1;
         iss_slot_in  = SLOT_XLEFT;
      end else if (adv && iss_valid_ff) begin
         if (iss_slot_ff == SLOT_ZBR) begin
            iss_valid_in = 1'b0;
         end else begin
            iss_slot_in = iss_slot_ff + 3'd1;
         end
      end
   end

   // Select the force and torque combination for this slot
   always_comb begin
      tx = {{2{wr_ff.torque_x[15]}}, wr_ff.torque_x};
      ty = {{2{wr_ff.torque_y[15]}}, wr_ff.torque_y};
      tz = {{2{wr_ff.torque_z[15]}}, wr_ff.torque_z};
      f_sel = iss_slot_ff[2] ? wr_ff.force_z :
              (iss_slot_ff[1] ? wr_ff.force_y : wr_ff.force_x);
      case (iss_slot_ff)
         SLOT_XLEFT:  t_sel = m12 ? (-tz - ty) : -tz;
         SLOT_XRIGHT: t_sel = m12 ? (tz - ty)  : tz;
         SLOT_YFRONT: t_sel = m12 ? (tx - tz)  : -tz;
         SLOT_YBACK:  t_sel = m12 ? (tz + tx)  : tz;
         SLOT_ZFL:    t_sel = tx - ty;
         SLOT_ZFR:    t_sel = -tx - ty;
         SLOT_ZBL:    t_sel = tx + ty;
         SLOT_ZBR:    t_sel = ty - tx;
         default:     t_sel = '0;
      endcase
      // eight-motor mode doubles the force term of the x and y pairs
      if (!m12 && !iss_slot_ff[2]) begin
         fterm = {f_sel[15], f_sel, 17'd0};
      end else begin
         fterm = {{2{f_sel[15]}}, f_sel, 16'd0};
      end
      tprod = t_sel * $signed({1'b0, cfg.inverse_arm_length});
   end

   // Stage 2 sum and magnitude
   always_comb begin
      s_sum = {{2{s1_fterm_ff[33]}}, s1_fterm_ff}
            + (s1_tc2_ff ? {s1_tprod_ff, 1'b0} : {s1_tprod_ff[34], s1_tprod_ff});
      s_abs = s_sum[35] ? (36'd0 - s_sum) : s_sum;
   end

   // Stage 3 gain partial products
   assign pp_hi = s2_abs_ff[33:17] * cfg.cmd_gain;
   assign pp_lo = s2_abs_ff[16:0]  * cfg.cmd_gain;

   // Finish: integer magnitude, saturate, double, dead band
   always_comb begin
      prod      = {s3_pp_hi_ff, 17'd0} + {17'd0, s3_pp_lo_ff};
      mag16     = prod[49:34];
      mag_sat   = (mag16 > {9'd0, cfg.speed_max}) ? cfg.speed_max : mag16[6:0];
      drive_pre = {mag_sat, 1'b0};
      drive     = (drive_pre < {1'b0, cfg.speed_min}) ? 8'd0 : drive_pre;
   end

   // Assemble the record; the last slot is overlaid on the way to the queue
   always_comb begin
      asm_in = asm_ff;
      if (s3_valid_ff) begin
         asm_in.drive[s3_slot_ff] = drive;
         asm_in.neg[s3_slot_ff]   = s3_neg_ff;
         asm_in.nz[s3_slot_ff]    = s3_nz_ff;
      end
      push_rec = asm_in;
      push     = s3_valid_ff && (s3_slot_ff == SLOT_ZBR) && !full;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_valid_ff <= 1'b0;
         iss_slot_ff  <= SLOT_XLEFT;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
      end else begin
         iss_valid_ff <= iss_valid_in;
         iss_slot_ff  <= iss_slot_in;
         if (adv) begin
            s1_valid_ff <= iss_valid_ff;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      wr_ff <= wr_in;
      if (adv) begin
         s1_tprod_ff <= tprod;
         s1_fterm_ff <= fterm;
         s1_tc2_ff   <= !m12;
         s1_slot_ff  <= iss_slot_ff;
         s2_abs_ff   <= s_abs[33:0];
         s2_neg_ff   <= s_sum[35];
         s2_nz_ff    <= (s_sum != 36'd0);
         s2_slot_ff  <= s1_slot_ff;
         s3_pp_hi_ff <= pp_hi;
         s3_pp_lo_ff <= pp_lo;
         s3_neg_ff   <= s2_neg_ff && (cfg.cmd_gain != 16'd0);
         s3_nz_ff    <= s2_nz_ff && (cfg.cmd_gain != 16'd0);
         s3_slot_ff  <= s2_slot_ff;
         asm_ff      <= asm_in;
      end
   end

   // A new wrench is only taken at the start or on the final slot of the last one
   assert property (@(posedge clock) disable iff (reset)
      take |=> (iss_valid_ff && iss_slot_ff == SLOT_XLEFT))
      else $error("wtm_front: wrench not started at first slot");

endmodule

// ===== sv/wtm_queue.sv =====
`timescale 1ns / 1ps

module wtm_queue import wtm_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   output logic    full,
   input  logic    pop,
   output rec_type head_rec,
   output logic    head_valid
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   rec_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_rec   = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("wtm_queue: push while full");
   assert property (@(posedge clock) disable iff (reset) !head_valid |-> !pop)
      else $error("wtm_queue: pop while empty");

endmodule

// ===== sv/wtm_back.sv =====
`timescale 1ns / 1ps

module wtm_back import wtm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        head_valid,
   input  rec_type     head_rec,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_slot,
   output logic [7:0]  rsp_drive,
   output logic [7:0]  rsp_direction,
   output logic        rsp_tlast
);

   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_slot_ff;
   logic [7:0] rsp_drive_ff, rsp_dir_ff;
   logic       rsp_last_ff;

   logic       gx, gy, gz, en, out_free, step, load, last_in;

   // Group enables: a group is sent if any member command is nonzero
   assign gx = |head_rec.nz[1:0];
   assign gy = |head_rec.nz[3:2];
   assign gz = |head_rec.nz[7:4];
   assign en = idx_ff[2] ? gz : (idx_ff[1] ? gy : gx);

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign step     = head_valid && (!en || out_free);
   assign load     = step && en;
   assign pop      = step && (idx_ff == SLOT_ZBR);

   // Mark the final slot of the last enabled group
   always_comb begin
      case (idx_ff)
         SLOT_XRIGHT: last_in = !gy && !gz;
         SLOT_YBACK:  last_in = !gz;
         SLOT_ZBR:    last_in = 1'b1;
         default:     last_in = 1'b0;
      endcase
   end

   // Walk the slots and hold the output word until taken
   always_comb begin
      idx_in       = step ? idx_ff + 3'd1 : idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= SLOT_XLEFT;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_slot_ff  <= idx_ff;
         rsp_drive_ff <= head_rec.drive[idx_ff];
         rsp_dir_ff   <= head_rec.neg[idx_ff] ? cfg.reverse_code : cfg.forward_code;
         rsp_last_ff  <= last_in;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_drive     = rsp_drive_ff;
   assign rsp_direction = rsp_dir_ff;
   assign rsp_tlast     = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (load && last_in) |-> (idx_ff == SLOT_XRIGHT || idx_ff == SLOT_YBACK
                             || idx_ff == SLOT_ZBR))
      else $error("wtm_back: last marked inside a group");
   assert property (@(posedge clock) disable iff (reset)
      (load && !out_free) |-> 1'b0)
      else $error("wtm_back: output word overwritten");

endmodule

// ===== sv/wrench_to_thruster_mixer.sv =====
`timescale 1ns / 1ps

// Wrench to thruster mixer. A wrench word (force_x..torque_z, signed Q8.8)
// is mixed into eight thruster commands, sent as up to eight result words
// in slot order 0..7, one word per cycle while the receiver is ready, with
// tlast on the final one; a pair or quad whose commands are all zero is
// skipped, and a wrench with nothing to send gives no word. The front end
// computes one motor slot a cycle, unless the queue is full, through a
// four-stage multiply pipeline, and takes a new wrench only when idle or
// on the final slot of the one before; the back end walks the eight slots
// of a finished wrench, stepping through the slots of skipped groups too.
// A queue of QUEUE_DEPTH finished wrenches (at least 2) sits between the
// two halves. The user must write control registers only while the block
// is idle; the block itself does not enforce this.
module wrench_to_thruster_mixer import wtm_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // force_x, force_y, force_z, torque_x, torque_y, torque_z (16 bits each)
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,
   // motor_slot[2:0], drive[10:3], direction[18:11], zero[23:19]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       push, full, pop, head_valid;
   rec_type    push_rec, head_rec;
   logic [2:0] rsp_slot;
   logic [7:0] rsp_drive, rsp_direction;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MODE:    cfg_in.twelve_motor_mode  = csr_wdata[0];
            CSR_GAIN:    cfg_in.cmd_gain           = csr_wdata;
            CSR_INV_ARM: cfg_in.inverse_arm_length = csr_wdata;
            CSR_SPD_MAX: cfg_in.speed_max          = csr_wdata[6:0];
            CSR_SPD_MIN: cfg_in.speed_min          = csr_wdata[6:0];
            CSR_FWD:     cfg_in.forward_code       = csr_wdata[7:0];
            CSR_REV:     cfg_in.reverse_code       = csr_wdata[7:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.twelve_motor_mode  <= 1'b0;
         cfg_ff.cmd_gain           <= 16'd256;
         cfg_ff.inverse_arm_length <= 16'd65535;
         cfg_ff.speed_max          <= 7'd127;
         cfg_ff.speed_min          <= 7'd0;
         cfg_ff.forward_code       <= 8'd0;
         cfg_ff.reverse_code       <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wtm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_wrench (wrench_type'(req_tdata)),
      .push       (push),
      .push_rec   (push_rec),
      .full       (full)
   );

   wtm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec   (push_rec),
      .full       (full),
      .pop        (pop),
      .head_rec   (head_rec),
      .head_valid (head_valid)
   );

   wtm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head_valid    (head_valid),
      .head_rec      (head_rec),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_slot      (rsp_slot),
      .rsp_drive     (rsp_drive),
      .rsp_direction (rsp_direction),
      .rsp_tlast     (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, rsp_direction, rsp_drive, rsp_slot};

endmodule

// ===== dv/tb_wrench_to_thruster_mixer.sv =====
`timescale 1ns / 1ps

module tb_wrench_to_thruster_mixer;
   import wtm_pkg::*;

   localparam int         SETTLE_CYCLES  = 48;
   localparam int         WATCHDOG_LIMIT = 1000;
   localparam int         PRINT_LIMIT    = 40;
   // Index past the register list: the block must ignore it
   localparam logic [2:0] CSR_NONE       = 3'd7;

   typedef struct {
      logic [2:0] slot;
      logic [7:0] drive;
      logic [7:0] direction;
      logic       last;
   } thrust_cmd_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   // Stimulus and prediction state
   logic [95:0]    pending_wrenches[$];
   thrust_cmd_type expected_cmds[$];
   thrust_cmd_type wanted_cmd;
   cfg_type        shadow_cfg;
   bit          idle_on     = 1'b0;
   bit          word_held   = 1'b0;
   int          send_gap    = 0;
   int          ready_gap   = 0;
   int          error_count = 0;
   int          quiet_cycles = 0;

   wrench_to_thruster_mixer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // One thruster command at scale 2^-34: gain * (fc*F/4 + tc*T/(4L))
   function automatic longint signed mix_cmd(longint signed f, longint signed t,
                                             longint signed fc, longint signed tc);
      longint signed s;
      s = fc * f * 64'sd65536 + tc * t * longint'(shadow_cfg.inverse_arm_length);
      return s * longint'(shadow_cfg.cmd_gain);
   endfunction

   // Saturate, apply dead band and double; sign picks the direction code
   function automatic void add_thrust_cmd(logic [2:0] slot, longint signed c);
      longint unsigned mag;
      thrust_cmd_type  cmd;
      mag = (c >= 0) ? longint'(c) : longint'(-c);
      mag = mag >> 34;
      if (mag > shadow_cfg.speed_max) mag = shadow_cfg.speed_max;
      if (2 * mag < shadow_cfg.speed_min) mag = 0;
      cmd.slot      = slot;
      cmd.drive     = 8'(2 * mag);
      cmd.direction = (c >= 0) ? shadow_cfg.forward_code : shadow_cfg.reverse_code;
      cmd.last      = 1'b0;
      expected_cmds = {expected_cmds, cmd};
   endfunction

   // Mix one wrench and queue the commands of every non-zero group
   function automatic void predict_thruster_cmds(logic [95:0] word);
      wrench_type    w;
      longint signed fx, fy, fz, tx, ty, tz, zt;
      longint signed xl, xr, yf, yb, zfl, zfr, zbl, zbr;
      int            first;
      w  = wrench_type'(word);
      fx = longint'($signed(w.force_x));
      fy = longint'($signed(w.force_y));
      fz = longint'($signed(w.force_z));
      tx = longint'($signed(w.torque_x));
      ty = longint'($signed(w.torque_y));
      tz = longint'($signed(w.torque_z));
      if (shadow_cfg.twelve_motor_mode) begin
         xl = mix_cmd(fx, -tz - ty, 1, 1);
         xr = mix_cmd(fx, tz - ty, 1, 1);
         yf = mix_cmd(fy, tz + tx, 1, 1);
         yb = mix_cmd(fy, -tz + tx, 1, 1);
         zt = 1;
      end else begin
         xl = mix_cmd(fx, -tz, 2, 2);
         xr = mix_cmd(fx, tz, 2, 2);
         yf = mix_cmd(fy, tz, 2, 2);
         yb = mix_cmd(fy, -tz, 2, 2);
         zt = 2;
      end
      zfl = mix_cmd(fz, tx - ty, 1, zt);
      zfr = mix_cmd(fz, -tx - ty, 1, zt);
      zbl = mix_cmd(fz, tx + ty, 1, zt);
      zbr = mix_cmd(fz, -tx + ty, 1, zt);
      first = expected_cmds.size();
      if (xl != 0 || xr != 0) begin
         add_thrust_cmd(SLOT_XLEFT, xl);
         add_thrust_cmd(SLOT_XRIGHT, xr);
      end
      // y slots are crossed: front carries the back command and vice versa
      if (yf != 0 || yb != 0) begin
         add_thrust_cmd(SLOT_YFRONT, yb);
         add_thrust_cmd(SLOT_YBACK, yf);
      end
      if (zfl != 0 || zfr != 0 || zbl != 0 || zbr != 0) begin
         add_thrust_cmd(SLOT_ZFL, zfl);
         add_thrust_cmd(SLOT_ZFR, zfr);
         add_thrust_cmd(SLOT_ZBL, zbl);
         add_thrust_cmd(SLOT_ZBR, zbr);
      end
      if (expected_cmds.size() > first)
         expected_cmds[expected_cmds.size() - 1].last = 1'b1;
   endfunction

   function automatic logic [95:0] make_wrench(logic [15:0] fx, logic [15:0] fy,
                                               logic [15:0] fz, logic [15:0] tx,
                                               logic [15:0] ty, logic [15:0] tz);
      return {tz, ty, tx, fz, fy, fx};
   endfunction

   // Mostly full-scale values, with zeros, small values and the rails mixed in
   function automatic logic [15:0] random_axis();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'($urandom_range(0, 1023) - 512);
         2:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Random wrench; now and then clear every term of one group
   function automatic logic [95:0] random_wrench();
      logic [15:0] fx, fy, fz, tx, ty, tz;
      fx = random_axis(); fy = random_axis(); fz = random_axis();
      tx = random_axis(); ty = random_axis(); tz = random_axis();
      case ($urandom_range(0, 7))
         0: begin fx = '0; ty = '0; tz = '0; end
         1: begin fy = '0; tx = '0; tz = '0; end
         2: begin fz = '0; tx = '0; ty = '0; end
         default: ;
      endcase
      return make_wrench(fx, fy, fz, tx, ty, tz);
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.twelve_motor_mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0:       c.cmd_gain = 16'($urandom_range(1, 64));
         1:       c.cmd_gain = 16'($urandom_range(64, 512));
         2:       c.cmd_gain = 16'($urandom);
         default: c.cmd_gain = 16'd256;
      endcase
      c.inverse_arm_length = $urandom_range(0, 1) ? 16'($urandom) : 16'hFFFF;
      c.speed_max    = 7'($urandom_range(0, 127));
      c.speed_min    = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(0, 16));
      c.forward_code = 8'($urandom);
      c.reverse_code = 8'($urandom);
      return c;
   endfunction

   // Write one register and keep the shadow copy in step
   task automatic write_reg(logic [2:0] index, logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_MODE:    shadow_cfg.twelve_motor_mode  = value[0];
         CSR_GAIN:    shadow_cfg.cmd_gain           = value;
         CSR_INV_ARM: shadow_cfg.inverse_arm_length = value;
         CSR_SPD_MAX: shadow_cfg.speed_max          = value[6:0];
         CSR_SPD_MIN: shadow_cfg.speed_min          = value[6:0];
         CSR_FWD:     shadow_cfg.forward_code       = value[7:0];
         CSR_REV:     shadow_cfg.reverse_code       = value[7:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_config(cfg_type c);
      write_reg(CSR_MODE, 16'(c.twelve_motor_mode));
      write_reg(CSR_GAIN, c.cmd_gain);
      write_reg(CSR_INV_ARM, c.inverse_arm_length);
      write_reg(CSR_SPD_MAX, 16'(c.speed_max));
      write_reg(CSR_SPD_MIN, 16'(c.speed_min));
      write_reg(CSR_FWD, 16'(c.forward_code));
      write_reg(CSR_REV, 16'(c.reverse_code));
   endtask

   // Hold until every wrench is taken and every command has come back
   task automatic drain();
      while (pending_wrenches.size() != 0 || word_held || expected_cmds.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Append one wrench to the sender's queue
   function automatic void queue_wrench(logic [95:0] word);
      pending_wrenches = {pending_wrenches, word};
   endfunction

   task automatic push_directed();
      queue_wrench(make_wrench('0, '0, '0, '0, '0, '0));
      queue_wrench(make_wrench(16'h7FFF, '0, '0, '0, '0, '0));
      queue_wrench(make_wrench(16'h8000, '0, '0, '0, '0, '0));
      queue_wrench(make_wrench('0, 16'h0100, '0, '0, '0, 16'h0200));
      queue_wrench(make_wrench('0, '0, 16'h8000, '0, '0, '0));
      queue_wrench(make_wrench('0, '0, '0, 16'h7FFF, 16'h8000, '0));
      queue_wrench(make_wrench('0, '0, '0, '0, '0, 16'h8000));
      // tiny negative force: drive truncates to zero but keeps the reverse code
      queue_wrench(make_wrench(16'hFFFF, '0, '0, '0, '0, '0));
      queue_wrench(make_wrench(16'h7FFF, 16'h7FFF, 16'h7FFF,
                               16'h7FFF, 16'h7FFF, 16'h7FFF));
      queue_wrench(make_wrench(16'h8000, 16'h8000, 16'h8000,
                               16'h8000, 16'h8000, 16'h8000));
      queue_wrench(make_wrench('0, '0, 16'h0001, '0, '0, '0));
      queue_wrench(make_wrench('0, '0, '0, 16'h0040, 16'h0080, '0));
   endtask

   // Sender: present queued wrenches, with short random gaps when enabled
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         word_held = 1'b0;
         send_gap  = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_thruster_cmds(req_tdata);
            word_held = 1'b0;
         end
         if (!word_held) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_wrenches.size() != 0) begin
               req_tdata  <= pending_wrenches.pop_front();
               req_tvalid <= 1'b1;
               word_held = 1'b1;
               if (idle_on && $urandom_range(0, 3) == 0)
                  send_gap = $urandom_range(1, 3);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: drop ready in random bursts when enabled
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_gap = 0;
      end else if (ready_gap > 0) begin
         ready_gap--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         ready_gap = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each command word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_cmds.size() == 0) begin
            report_mismatch("unexpected word, slot", int'(rsp_tdata[2:0]), -1);
         end else begin
            wanted_cmd = expected_cmds.pop_front();
            if (rsp_tdata[2:0] != wanted_cmd.slot)
               report_mismatch("motor_slot", int'(rsp_tdata[2:0]), int'(wanted_cmd.slot));
            if (rsp_tdata[10:3] != wanted_cmd.drive)
               report_mismatch("drive", int'(rsp_tdata[10:3]), int'(wanted_cmd.drive));
            if (rsp_tdata[18:11] != wanted_cmd.direction)
               report_mismatch("direction", int'(rsp_tdata[18:11]),
                               int'(wanted_cmd.direction));
            if (rsp_tlast != wanted_cmd.last)
               report_mismatch("last", int'(rsp_tlast), int'(wanted_cmd.last));
         end
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[wrench_to_thruster_mixer] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      cfg_type phase_cfg;
      shadow_cfg = '{1'b0, 16'd256, 16'hFFFF, 7'd127, 7'd0, 8'd0, 8'd1};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Out-of-range index must leave every register alone
      write_reg(CSR_NONE, 16'hFFFF);

      // Directed wrenches at reset settings, then in twelve-motor mode
      idle_on = 1'b1;
      push_directed();
      drain();
      phase_cfg = '{1'b1, 16'd256, 16'hFFFF, 7'd50, 7'd20, 8'hA5, 8'h5A};
      apply_config(phase_cfg);
      idle_on = 1'b0;
      push_directed();
      drain();

      // Register extremes
      phase_cfg = '{1'b1, 16'hFFFF, 16'h0000, 7'd127, 7'd127, 8'hFF, 8'h00};
      apply_config(phase_cfg);
      idle_on = 1'b1;
      repeat (15) queue_wrench(random_wrench());
      drain();
      phase_cfg = '{1'b0, 16'h0000, 16'hFFFF, 7'd0, 7'd0, 8'h00, 8'hFF};
      apply_config(phase_cfg);
      repeat (8) queue_wrench(random_wrench());
      drain();
      phase_cfg = '{1'b0, 16'hFFFF, 16'hFFFF, 7'd0, 7'd1, 8'h3C, 8'hC3};
      apply_config(phase_cfg);
      repeat (8) queue_wrench(random_wrench());
      drain();

      // Random settings, idling switched on and off between phases
      repeat (5) begin
         apply_config(random_cfg());
         idle_on = ($urandom_range(0, 3) != 0);
         repeat (10) queue_wrench(random_wrench());
         drain();
      end

      // Back to reset values with both sides running flat out
      phase_cfg = '{1'b0, 16'd256, 16'hFFFF, 7'd127, 7'd0, 8'd0, 8'd1};
      apply_config(phase_cfg);
      idle_on = 1'b0;
      repeat (16) queue_wrench(random_wrench());
      drain();

      if (error_count == 0)
         $display("[wrench_to_thruster_mixer] OK");
      else
         $display("[wrench_to_thruster_mixer] ERROR");
      $finish;
   end

endmodule
